### rtl/pskc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM setting knob controller package
// Shared constants, command codes and the queue entry type.
// ----------------------------------------------------------------------------
package pskc_pkg;

    localparam int FREQ_W   = 14;
    localparam int DUTY_W   = 7;
    localparam int HALF_W   = 8;
    localparam int RES_W    = 20;
    localparam int DIV_W    = 24;
    localparam int CNT_W    = 5;
    localparam int NPRESET  = 4;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 14;
    localparam int QDEPTH   = 2;

    localparam logic [FREQ_W-1:0] FREQ_MIN   = 14'd10;
    localparam logic [FREQ_W-1:0] FREQ_MAX   = 14'd10000;
    localparam logic [FREQ_W-1:0] FREQ_RST   = 14'd50;
    localparam logic [FREQ_W-1:0] UP_BAND_HI = 14'd1000;
    localparam logic [FREQ_W-1:0] UP_BAND_LO = 14'd100;
    localparam logic [FREQ_W-1:0] DN_BAND_HI = 14'd2000;
    localparam logic [FREQ_W-1:0] DN_BAND_LO = 14'd200;
    localparam logic [FREQ_W-1:0] STEP_BIG   = 14'd500;
    localparam logic [FREQ_W-1:0] STEP_MID   = 14'd50;
    localparam logic [FREQ_W-1:0] STEP_FINE  = 14'd5;
    localparam logic [HALF_W-1:0] HALF_MAX   = 8'd200;
    localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;

    localparam logic [DIV_W-1:0] RELOAD_NUM    = 24'd10000000;
    localparam logic [DIV_W-1:0] COMPARE_SCALE = 24'd100000;

    localparam logic [DUTY_W-1:0] PRESET_DUTY_RST_A = 7'd0;
    localparam logic [DUTY_W-1:0] PRESET_DUTY_RST_B = 7'd10;
    localparam logic [DUTY_W-1:0] PRESET_DUTY_RST_C = 7'd3;
    localparam logic [DUTY_W-1:0] PRESET_DUTY_RST_D = 7'd12;

    // Number of configuration registers: frequency and duty for each preset.
    localparam logic [CFG_IDX_W-1:0] CFG_NREGS = 4'd8;

    typedef enum logic [1:0] {
        CMD_FREQ   = 2'd0,
        CMD_DUTY   = 2'd1,
        CMD_PRESET = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUTY_W-1:0] duty;
    } qentry_t;

endpackage

### rtl/pskc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM setting knob controller front end
// Accepts events, updates frequency and duty state, holds the presets.
// ----------------------------------------------------------------------------
module pskc_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ev_valid,
    input  logic [1:0]                    ev_cmd,
    input  logic                          ev_down,
    input  logic [1:0]                    ev_sel,
    input  logic                          cfg_we,
    input  logic [pskc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [pskc_pkg::CFG_DAT_W-1:0] cfg_wdata,
    output pskc_pkg::qentry_t             push_entry
);

    logic [pskc_pkg::FREQ_W-1:0] freq_reg, freq_next;
    logic [pskc_pkg::HALF_W-1:0] half_reg, half_next;
    logic [pskc_pkg::FREQ_W-1:0] pfreq_reg [pskc_pkg::NPRESET];
    logic [pskc_pkg::DUTY_W-1:0] pduty_reg [pskc_pkg::NPRESET];

    logic [pskc_pkg::FREQ_W-1:0] step;
    logic [pskc_pkg::FREQ_W-1:0] fsum;
    logic [pskc_pkg::FREQ_W-1:0] pf;
    logic [pskc_pkg::DUTY_W-1:0] pd;

    always_comb begin
        freq_next = freq_reg;
        half_next = half_reg;
        step      = pskc_pkg::STEP_FINE;
        fsum      = freq_reg;
        pf        = pfreq_reg[ev_sel];
        pd        = pduty_reg[ev_sel];
        case (pskc_pkg::cmd_t'(ev_cmd))
            pskc_pkg::CMD_FREQ: begin
                if (!ev_down) begin
                    if (freq_reg >= pskc_pkg::UP_BAND_HI) begin
                        step = pskc_pkg::STEP_BIG;
                    end else if (freq_reg >= pskc_pkg::UP_BAND_LO) begin
                        step = pskc_pkg::STEP_MID;
                    end
                    fsum = freq_reg + step;
                end else begin
                    if (freq_reg >= pskc_pkg::DN_BAND_HI) begin
                        step = pskc_pkg::STEP_BIG;
                    end else if (freq_reg >= pskc_pkg::DN_BAND_LO) begin
                        step = pskc_pkg::STEP_MID;
                    end
                    fsum = (freq_reg >= step + pskc_pkg::FREQ_MIN) ? freq_reg - step
                                                                    : pskc_pkg::FREQ_MIN;
                end
                if (fsum > pskc_pkg::FREQ_MAX) begin
                    freq_next = pskc_pkg::FREQ_MAX;
                end else if (fsum < pskc_pkg::FREQ_MIN) begin
                    freq_next = pskc_pkg::FREQ_MIN;
                end else begin
                    freq_next = fsum;
                end
            end
            pskc_pkg::CMD_DUTY: begin
                if (!ev_down) begin
                    if (half_reg < pskc_pkg::HALF_MAX) begin
                        half_next = half_reg + 8'd1;
                    end
                end else if (half_reg != '0) begin
                    half_next = half_reg - 8'd1;
                end
            end
            pskc_pkg::CMD_PRESET: begin
                // Presets are saturated on use, so any written value is safe.
                if (pf < pskc_pkg::FREQ_MIN) begin
                    freq_next = pskc_pkg::FREQ_MIN;
                end else if (pf > pskc_pkg::FREQ_MAX) begin
                    freq_next = pskc_pkg::FREQ_MAX;
                end else begin
                    freq_next = pf;
                end
                if (pd > pskc_pkg::DUTY_MAX) begin
                    half_next = {pskc_pkg::DUTY_MAX, 1'b0};
                end else begin
                    half_next = {pd, 1'b0};
                end
            end
            default: begin
                // The unused command keeps the settings.
                freq_next = freq_reg;
                half_next = half_reg;
            end
        endcase
    end

    assign push_entry.freq = freq_next;
    assign push_entry.duty = half_next[pskc_pkg::HALF_W-1:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg     <= pskc_pkg::FREQ_RST;
            half_reg     <= '0;
            pfreq_reg[0] <= pskc_pkg::FREQ_RST;
            pfreq_reg[1] <= pskc_pkg::FREQ_RST;
            pfreq_reg[2] <= pskc_pkg::FREQ_RST;
            pfreq_reg[3] <= pskc_pkg::FREQ_RST;
            pduty_reg[0] <= pskc_pkg::PRESET_DUTY_RST_A;
            pduty_reg[1] <= pskc_pkg::PRESET_DUTY_RST_B;
            pduty_reg[2] <= pskc_pkg::PRESET_DUTY_RST_C;
            pduty_reg[3] <= pskc_pkg::PRESET_DUTY_RST_D;
        end else begin
            if (ev_valid) begin
                freq_reg <= freq_next;
                half_reg <= half_next;
            end
            if (cfg_we && (cfg_idx < pskc_pkg::CFG_NREGS)) begin
                if (cfg_idx[0]) begin
                    pduty_reg[cfg_idx[2:1]] <= cfg_wdata[pskc_pkg::DUTY_W-1:0];
                end else begin
                    pfreq_reg[cfg_idx[2:1]] <= cfg_wdata[pskc_pkg::FREQ_W-1:0];
                end
            end
        end
    end

    a_freq_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (freq_reg >= pskc_pkg::FREQ_MIN) && (freq_reg <= pskc_pkg::FREQ_MAX))
        else $error("frequency state left its range");

    a_half_range: assert property (@(posedge aclk) disable iff (!aresetn)
        half_reg <= pskc_pkg::HALF_MAX)
        else $error("duty half-step count above its limit");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ev_valid |=> $stable(freq_reg) && $stable(half_reg))
        else $error("settings changed without an event");

endmodule

### rtl/pskc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM setting knob controller queue
// Two-entry FIFO between the event front end and the divider back end.
// ----------------------------------------------------------------------------
module pskc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pskc_pkg::qentry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output pskc_pkg::qentry_t head_entry
);

    pskc_pkg::qentry_t mem_reg [pskc_pkg::QDEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = (count_reg == 2'(pskc_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full && !pop))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !head_valid))
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(pskc_pkg::QDEPTH))
        else $error("queue count beyond its depth");

endmodule

### rtl/pskc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM setting knob controller back end
// Computes reload and compare with two bit-serial dividers and holds the result.
// ----------------------------------------------------------------------------
module pskc_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         head_valid,
    input  pskc_pkg::qentry_t            head_entry,
    output logic                         pop,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [pskc_pkg::RES_W-1:0]   res_reload,
    output logic [pskc_pkg::RES_W-1:0]   res_compare,
    output logic [pskc_pkg::FREQ_W-1:0] res_freq,
    output logic [pskc_pkg::DUTY_W-1:0] res_duty
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                       state_reg;
    logic [pskc_pkg::FREQ_W-1:0]  freq_reg;
    logic [pskc_pkg::DUTY_W-1:0]  duty_reg;
    logic [pskc_pkg::DIV_W-1:0]   num_r_reg, num_c_reg;
    logic [pskc_pkg::FREQ_W-1:0]  rem_r_reg, rem_c_reg;
    logic [pskc_pkg::CNT_W-1:0]   cnt_reg;
    logic                         out_valid_reg;
    logic [pskc_pkg::RES_W-1:0]   out_reload_reg, out_compare_reg;
    logic [pskc_pkg::FREQ_W-1:0]  out_freq_reg;
    logic [pskc_pkg::DUTY_W-1:0]  out_duty_reg;

    logic [pskc_pkg::FREQ_W:0]    trial_r, trial_c;
    logic                         ge_r, ge_c;
    logic [pskc_pkg::FREQ_W-1:0]  rem_r_next, rem_c_next;
    logic                         out_free;

    // One restoring step per cycle: bring in the next numerator bit and
    // subtract the divisor when it fits.
    always_comb begin
        trial_r    = {rem_r_reg, num_r_reg[pskc_pkg::DIV_W-1]};
        trial_c    = {rem_c_reg, num_c_reg[pskc_pkg::DIV_W-1]};
        ge_r       = (trial_r >= {1'b0, freq_reg});
        ge_c       = (trial_c >= {1'b0, freq_reg});
        rem_r_next = ge_r ? pskc_pkg::FREQ_W'(trial_r - {1'b0, freq_reg})
                          : trial_r[pskc_pkg::FREQ_W-1:0];
        rem_c_next = ge_c ? pskc_pkg::FREQ_W'(trial_c - {1'b0, freq_reg})
                          : trial_c[pskc_pkg::FREQ_W-1:0];
    end

    assign out_free = !out_valid_reg || res_ready;
    assign pop      = (state_reg == ST_IDLE) && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            // A taken result clears the output register unless a new one is
            // loaded at the same edge.
            if (out_valid_reg && res_ready && (state_reg != ST_DONE)) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (head_valid) begin
                        freq_reg  <= head_entry.freq;
                        duty_reg  <= head_entry.duty;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    num_r_reg <= pskc_pkg::RELOAD_NUM;
                    num_c_reg <= pskc_pkg::DIV_W'(pskc_pkg::DIV_W'(duty_reg)
                                                  * pskc_pkg::COMPARE_SCALE);
                    rem_r_reg <= '0;
                    rem_c_reg <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    num_r_reg <= {num_r_reg[pskc_pkg::DIV_W-2:0], ge_r};
                    num_c_reg <= {num_c_reg[pskc_pkg::DIV_W-2:0], ge_c};
                    rem_r_reg <= rem_r_next;
                    rem_c_reg <= rem_c_next;
                    cnt_reg   <= cnt_reg + 5'd1;
                    if (cnt_reg == pskc_pkg::CNT_W'(pskc_pkg::DIV_W - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_valid_reg   <= 1'b1;
                        out_reload_reg  <= num_r_reg[pskc_pkg::RES_W-1:0];
                        out_compare_reg <= num_c_reg[pskc_pkg::RES_W-1:0];
                        out_freq_reg    <= freq_reg;
                        out_duty_reg    <= duty_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid   = out_valid_reg;
    assign res_reload  = out_reload_reg;
    assign res_compare = out_compare_reg;
    assign res_freq    = out_freq_reg;
    assign res_duty    = out_duty_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg < pskc_pkg::CNT_W'(pskc_pkg::DIV_W)))
        else $error("divider step count overran");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (rem_r_reg < freq_reg) && (rem_c_reg < freq_reg))
        else $error("divider remainder not below the divisor");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !res_ready) |=> out_valid_reg && $stable(out_reload_reg))
        else $error("pending result overwritten");

endmodule

### rtl/pwm_setting_knob_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM setting knob controller
// Keeps a PWM frequency and duty from knob and button events and reports the
// timer reload and compare counts for every event.
// ----------------------------------------------------------------------------
// An accepted event is written into the queue; the back end takes it when
// idle, runs both divisions and loads the result onto m_ once it is free.
// The back end takes a new event only after the last result is loaded; the
// two 24-step bit-serial dividers run side by side and take one bit a cycle.
// Reset: aresetn is synchronous and active low; it restores frequency 50 Hz,
// duty 0 and the preset reset values, and empties the queue and result stage.
// ----------------------------------------------------------------------------
module pwm_setting_knob_controller_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Event channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: [1:0] cmd, [2] direction, [4:3] preset_index, [7:5] zero
    input  logic [7:0]                        s_tdata,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: [19:0] reload_value, [39:20] compare_value,
    //          [53:40] frequency_hz, [60:54] duty_percent, [63:61] zero
    output logic [63:0]                       m_tdata,
    // Configuration write channel: index 0..7 selects the preset registers.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pskc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pskc_pkg::CFG_DAT_W-1:0]    cfg_data
);

    // An event transaction is taken whenever the queue has room. The front
    // end updates the settings in the same cycle and pushes the new frequency
    // and whole-percent duty, so later events see the updated state at once.
    logic              ev_accept;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    pskc_pkg::qentry_t q_push_entry;
    pskc_pkg::qentry_t q_head_entry;

    logic [pskc_pkg::RES_W-1:0]  res_reload;
    logic [pskc_pkg::RES_W-1:0]  res_compare;
    logic [pskc_pkg::FREQ_W-1:0] res_freq;
    logic [pskc_pkg::DUTY_W-1:0] res_duty;

    assign s_tready  = !q_full;
    assign ev_accept = s_tvalid && !q_full;

    // Configuration writes are always taken; the preset registers are only
    // read when an event selects one.
    assign cfg_ready = 1'b1;

    pskc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ev_valid   (ev_accept),
        .ev_cmd     (s_tdata[1:0]),
        .ev_down    (s_tdata[2]),
        .ev_sel     (s_tdata[4:3]),
        .cfg_we     (cfg_valid),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .push_entry (q_push_entry)
    );

    pskc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (ev_accept),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head_entry)
    );

    // The back end works on one queued setting at a time: it forms the
    // compare numerator with one multiply, runs both divisions, and loads
    // the output register as soon as the previous result has been taken.
    pskc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (q_valid),
        .head_entry  (q_head_entry),
        .pop         (q_pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_reload  (res_reload),
        .res_compare (res_compare),
        .res_freq    (res_freq),
        .res_duty    (res_duty)
    );

    assign m_tdata = {3'b000, res_duty, res_freq, res_compare, res_reload};

endmodule
